[rtl/core/esc_pkg.sv]
// ----------------------------------------------------------------------------
// esc_pkg: shared definitions for the expression syntax checker
// Character classes, operator slot layout, register indexes and defaults.
// ----------------------------------------------------------------------------
package esc_pkg;

  // configuration register widths
  localparam int DIGIT_CHARS_W = 64;
  localparam int DIGIT_COUNT_W = 4;
  localparam int OP_CHARS_W    = 56;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 2;
  localparam int CHAR_W        = 8;

  // operator slots: open, close, plus, minus, multiply, divide, modulo
  localparam int OP_COUNT        = 7;
  localparam int OP_FIRST_ARITH  = 2;
  localparam int OP_FIRST_MULDIV = 4;
  localparam int OP_IDX_W        = 3;

  // parameter defaults
  localparam int DIGIT_MAX_DEF  = 8;
  localparam int DEPTH_BITS_DEF = 16;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_CHARS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OP_CHARS    = 2'd2;

  // character classes
  typedef enum logic [2:0] {
    CL_NONE,
    CL_DIGIT,
    CL_OPEN,
    CL_CLOSE,
    CL_ADDSUB,
    CL_MULDIV,
    CL_OTHER
  } cls_t;

  // plus, minus, multiply, divide or modulo
  function automatic logic is_arith(input cls_t cl);
    is_arith = (cl == CL_ADDSUB) || (cl == CL_MULDIV);
  endfunction

endpackage

[rtl/core/esc_if.sv]
// ----------------------------------------------------------------------------
// esc_in_if / esc_out_if: valid/ready channels of the syntax checker
// Character channel in, verdict channel out.
// ----------------------------------------------------------------------------
interface esc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_mark;

  modport source (output valid, output char_code, output end_mark, input ready);
  modport sink   (input valid, input char_code, input end_mark, output ready);
endinterface

interface esc_out_if;
  logic valid;
  logic ready;
  logic verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

[rtl/core/esc_classify.sv]
// ----------------------------------------------------------------------------
// esc_classify: character classifier
// Parallel compares against the digit and operator bytes; first match wins.
// ----------------------------------------------------------------------------
module esc_classify #(
  parameter int DIGIT_MAX = esc_pkg::DIGIT_MAX_DEF
) (
  input  logic [esc_pkg::CHAR_W-1:0]        char_code,
  input  logic [esc_pkg::DIGIT_CHARS_W-1:0] digit_chars,
  input  logic [esc_pkg::DIGIT_COUNT_W-1:0] digit_count,
  input  logic [esc_pkg::OP_CHARS_W-1:0]    op_chars,
  output esc_pkg::cls_t                     cls
);

  logic [esc_pkg::DIGIT_COUNT_W-1:0] n_dig;
  logic [DIGIT_MAX-1:0]              dig_hit;
  logic [esc_pkg::OP_COUNT-1:0]      op_hit;
  logic [esc_pkg::OP_IDX_W-1:0]      op_idx;

  // clamp the digit count
  assign n_dig = (digit_count > esc_pkg::DIGIT_COUNT_W'(DIGIT_MAX)) ?
                 esc_pkg::DIGIT_COUNT_W'(DIGIT_MAX) : digit_count;

  // byte compares
  always_comb begin
    for (int i = 0; i < DIGIT_MAX; i++) begin
      dig_hit[i] = (esc_pkg::DIGIT_COUNT_W'(i) < n_dig) &&
                   (char_code == digit_chars[8*i +: 8]);
    end
    for (int j = 0; j < esc_pkg::OP_COUNT; j++) begin
      op_hit[j] = (char_code == op_chars[8*j +: 8]);
    end
  end

  // lowest matching operator slot
  always_comb begin
    op_idx = '0;
    for (int j = esc_pkg::OP_COUNT - 1; j >= 0; j--) begin
      if (op_hit[j]) op_idx = esc_pkg::OP_IDX_W'(j);
    end
  end

  // class select: digits first
  always_comb begin
    if (|dig_hit) begin
      cls = esc_pkg::CL_DIGIT;
    end else if (!(|op_hit)) begin
      cls = esc_pkg::CL_OTHER;
    end else if (op_idx == esc_pkg::OP_IDX_W'(0)) begin
      cls = esc_pkg::CL_OPEN;
    end else if (op_idx < esc_pkg::OP_IDX_W'(esc_pkg::OP_FIRST_ARITH)) begin
      cls = esc_pkg::CL_CLOSE;
    end else if (op_idx < esc_pkg::OP_IDX_W'(esc_pkg::OP_FIRST_MULDIV)) begin
      cls = esc_pkg::CL_ADDSUB;
    end else begin
      cls = esc_pkg::CL_MULDIV;
    end
  end

endmodule

[rtl/core/esc_cfg_check.sv]
// ----------------------------------------------------------------------------
// esc_cfg_check: configuration sanity check
// Flags zero bytes, digit/operator overlap and repeated bytes.
// ----------------------------------------------------------------------------
module esc_cfg_check #(
  parameter int DIGIT_MAX = esc_pkg::DIGIT_MAX_DEF
) (
  input  logic [esc_pkg::DIGIT_CHARS_W-1:0] digit_chars,
  input  logic [esc_pkg::DIGIT_COUNT_W-1:0] digit_count,
  input  logic [esc_pkg::OP_CHARS_W-1:0]    op_chars,
  output logic                              cfg_ok
);

  logic [esc_pkg::DIGIT_COUNT_W-1:0] n_dig;
  logic                              bad;

  assign n_dig = (digit_count > esc_pkg::DIGIT_COUNT_W'(DIGIT_MAX)) ?
                 esc_pkg::DIGIT_COUNT_W'(DIGIT_MAX) : digit_count;

  // all pairwise compares are independent; OR them together
  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < esc_pkg::OP_COUNT; i++) begin
      if (op_chars[8*i +: 8] == 8'h00) bad = 1'b1;
      for (int j = i + 1; j < esc_pkg::OP_COUNT; j++) begin
        if (op_chars[8*i +: 8] == op_chars[8*j +: 8]) bad = 1'b1;
      end
    end
    for (int i = 0; i < DIGIT_MAX; i++) begin
      if (esc_pkg::DIGIT_COUNT_W'(i) < n_dig) begin
        if (digit_chars[8*i +: 8] == 8'h00) bad = 1'b1;
        for (int j = 0; j < esc_pkg::OP_COUNT; j++) begin
          if (digit_chars[8*i +: 8] == op_chars[8*j +: 8]) bad = 1'b1;
        end
        for (int j = i + 1; j < DIGIT_MAX; j++) begin
          if ((esc_pkg::DIGIT_COUNT_W'(j) < n_dig) &&
              (digit_chars[8*i +: 8] == digit_chars[8*j +: 8])) bad = 1'b1;
        end
      end
    end
  end

  assign cfg_ok = !bad;

endmodule

[rtl/core/expression_syntax_checker.sv]
// ----------------------------------------------------------------------------
// expression_syntax_checker: streaming arithmetic expression syntax check
// Classifies each character and tracks depth and the previous class.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one character per transfer, or an end marker (end_mark=1)
//   that closes the expression. out_ch carries one verdict per end marker
//   (0 correct, 1 error); characters produce no transfer on out_ch. The user
//   must write configuration (digit bytes, digit count, operator bytes) via
//   cfg_we/cfg_index/cfg_wdata only while no expression is in flight (not enforced).
// Timing:
//   One transfer per cycle sustained while no end marker waits on out_ch. An
//   item is held in the input register; an end marker's verdict is then
//   loaded into the output register, which drives out_ch.
// Reset:
//   rst_n low clears the configuration to zero, the expression state and
//   both valid flags.
// Stall:
//   A verdict waits in the output register while out_ch.ready is low.
//   Characters keep flowing; an end marker held behind a waiting verdict
//   stops in_ch.ready until that verdict is taken.
// ----------------------------------------------------------------------------
module expression_syntax_checker #(
  parameter int DIGIT_MAX  = esc_pkg::DIGIT_MAX_DEF,
  parameter int DEPTH_BITS = esc_pkg::DEPTH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  esc_in_if.sink                          in_ch,
  esc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [esc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [esc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam logic signed [DEPTH_BITS-1:0] DMAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] DMIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

  // configuration registers
  logic [esc_pkg::DIGIT_CHARS_W-1:0] digit_chars_r;
  logic [esc_pkg::DIGIT_COUNT_W-1:0] digit_count_r;
  logic [esc_pkg::OP_CHARS_W-1:0]    op_chars_r;

  // input register
  logic                      s1_vld_r;
  logic [esc_pkg::CHAR_W-1:0] s1_char_r;
  logic                      s1_end_r;

  // expression state
  logic signed [DEPTH_BITS-1:0] depth_r, depth_nxt;
  esc_pkg::cls_t                prev_r, prev_nxt;
  logic                         err_r, err_nxt;
  logic                         seen_r, seen_nxt;

  // output register
  logic out_vld_r, out_vld_nxt;
  logic verdict_r, verdict_nxt;

  esc_pkg::cls_t cls;
  logic          cfg_ok;
  logic          out_free;
  logic          s1_adv;
  logic          in_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_chars_r <= '0;
      digit_count_r <= '0;
      op_chars_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        esc_pkg::REG_DIGIT_CHARS: digit_chars_r <= cfg_wdata;
        esc_pkg::REG_DIGIT_COUNT: digit_count_r <= cfg_wdata[esc_pkg::DIGIT_COUNT_W-1:0];
        esc_pkg::REG_OP_CHARS:    op_chars_r    <= cfg_wdata[esc_pkg::OP_CHARS_W-1:0];
        default: ;
      endcase
    end
  end

  esc_classify #(.DIGIT_MAX(DIGIT_MAX)) u_classify (
    .char_code   (s1_char_r),
    .digit_chars (digit_chars_r),
    .digit_count (digit_count_r),
    .op_chars    (op_chars_r),
    .cls         (cls)
  );

  esc_cfg_check #(.DIGIT_MAX(DIGIT_MAX)) u_cfg_check (
    .digit_chars (digit_chars_r),
    .digit_count (digit_count_r),
    .op_chars    (op_chars_r),
    .cfg_ok      (cfg_ok)
  );

  // flow control: a character always advances, an end marker needs the slot
  assign out_free    = !out_vld_r || out_ch.ready;
  assign s1_adv      = s1_vld_r && (!s1_end_r || out_free);
  assign in_ch.ready = !s1_vld_r || s1_adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_take) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_ch.char_code;
      s1_end_r  <= in_ch.end_mark;
    end
  end

  // state update and verdict
  always_comb begin
    depth_nxt   = depth_r;
    prev_nxt    = prev_r;
    err_nxt     = err_r;
    seen_nxt    = seen_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    verdict_nxt = verdict_r;
    if (s1_adv) begin
      if (s1_end_r) begin
        verdict_nxt = err_r || !seen_r || (depth_r != '0) ||
                      esc_pkg::is_arith(prev_r) || !cfg_ok;
        out_vld_nxt = 1'b1;
        depth_nxt   = '0;
        prev_nxt    = esc_pkg::CL_NONE;
        err_nxt     = 1'b0;
        seen_nxt    = 1'b0;
      end else begin
        seen_nxt = 1'b1;
        if (cls == esc_pkg::CL_OTHER) err_nxt = 1'b1;
        if (prev_r == esc_pkg::CL_DIGIT && cls == esc_pkg::CL_OPEN) err_nxt = 1'b1;
        if (prev_r == esc_pkg::CL_CLOSE && cls == esc_pkg::CL_DIGIT) err_nxt = 1'b1;
        if (esc_pkg::is_arith(prev_r) && cls == esc_pkg::CL_MULDIV) err_nxt = 1'b1;
        // saturating depth
        if (cls == esc_pkg::CL_OPEN) begin
          if (depth_r == DMAX) err_nxt = 1'b1;
          else depth_nxt = depth_r + DEPTH_BITS'(1);
        end else if (cls == esc_pkg::CL_CLOSE) begin
          if (depth_r == DMIN) err_nxt = 1'b1;
          else depth_nxt = depth_r - DEPTH_BITS'(1);
        end
        prev_nxt = (cls == esc_pkg::CL_OTHER) ? esc_pkg::CL_NONE : cls;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r   <= '0;
      prev_r    <= esc_pkg::CL_NONE;
      err_r     <= 1'b0;
      seen_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      depth_r   <= depth_nxt;
      prev_r    <= prev_nxt;
      err_r     <= err_nxt;
      seen_r    <= seen_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.verdict = verdict_r;

  // checks
  a_char_sets_seen: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !s1_end_r |=> seen_r)
    else $error("character did not mark the expression as started");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_end_r |=> !seen_r && !err_r && (depth_r == '0) &&
                           (prev_r == esc_pkg::CL_NONE) && out_vld_r)
    else $error("end marker did not clear state or load a verdict");

  a_end_waits: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s1_end_r && !out_free |=> s1_vld_r && s1_end_r)
    else $error("end marker dropped while verdict slot was busy");

  a_out_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(s1_adv && s1_end_r))
    else $error("verdict appeared without an end marker");

endmodule
